/* sv/ffba_pkg.sv */
// Shared types and codes for the first-fit bandwidth allocator.
package ffba_pkg;

  // Input item operation codes (s_tuser)
  localparam logic [1:0] FUNC_CAP    = 2'd0;
  localparam logic [1:0] FUNC_LAT    = 2'd1;
  localparam logic [1:0] FUNC_DEMAND = 2'd2;
  localparam logic [1:0] FUNC_STEP   = 2'd3;

  // Result kinds (m_tuser)
  localparam logic KIND_GRANT = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // Register map: register index taken from paddr[2]
  localparam logic REG_LATENCY_LIMIT = 1'b0;
  localparam logic [15:0] LIMIT_RESET = 16'd400;

  // Fixed field widths
  localparam int EDGE_W   = 5;
  localparam int CLIENT_W = 7;
  localparam int VALUE_W  = 20;
  localparam int LAT_W    = 16;
  localparam int STEPS_W  = 16;

  // Token moving down the cell row
  typedef struct packed {
    logic valid;
    logic step;   // 1: end of step sweep, 0: demand walk
  } tok_ctl_t;

  // Result offered by one cell; all zero when the cell has nothing
  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic                 last;
    logic [EDGE_W-1:0]    edge_id;
    logic [VALUE_W-1:0]   amount;
    logic [STEPS_W-1:0]   steps;
  } cell_res_t;

endpackage

/* sv/ffba_cell.sv */
// One edge of the allocator: capacity, usage, step count and latency column.
module ffba_cell #(
  parameter int IDX         = 0,
  parameter int NUM_EDGES   = 32,
  parameter int NUM_CLIENTS = 128,
  parameter int BW_BITS     = 20,
  parameter int CLI_AW      = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  // token from the left neighbor, token to the right neighbor
  input  ffba_pkg::tok_ctl_t            in_ctl,
  input  logic [BW_BITS-1:0]            in_left,
  output ffba_pkg::tok_ctl_t            out_ctl,
  output logic [BW_BITS-1:0]            out_left,
  // broadcast from the top level
  input  logic                          client_ok,
  input  logic [ffba_pkg::LAT_W-1:0]    limit,
  input  logic [CLI_AW-1:0]             rd_addr,
  input  logic [ffba_pkg::EDGE_W-1:0]   wr_edge,
  input  logic                          cap_we,
  input  logic                          lat_we,
  input  logic [CLI_AW-1:0]             wr_addr,
  input  logic [BW_BITS-1:0]            wr_value,
  input  logic [ffba_pkg::LAT_W-1:0]    wr_lat,
  output ffba_pkg::cell_res_t           res
);

  localparam logic IN_RANGE = (IDX < (1 << ffba_pkg::EDGE_W));
  localparam logic IS_LAST  = (IDX == NUM_EDGES - 1);

  logic [BW_BITS-1:0]               capacity;
  logic [BW_BITS-1:0]               remaining;
  logic [BW_BITS-1:0]               used;
  logic [ffba_pkg::STEPS_W-1:0]     nz_steps;
  logic [ffba_pkg::LAT_W-1:0]       lat_mem [NUM_CLIENTS];
  logic [ffba_pkg::LAT_W-1:0]       lat_q;

  logic                             sel;
  logic                             usable;
  logic [BW_BITS-1:0]               grant;
  logic [BW_BITS:0]                 sum;
  logic [BW_BITS-1:0]               used_sat;
  logic                             nz_inc;
  logic [ffba_pkg::STEPS_W-1:0]     nz_new;
  logic [BW_BITS+ffba_pkg::VALUE_W-1:0] grant_ext;
  logic [BW_BITS+ffba_pkg::VALUE_W-1:0] used_ext;
  logic                             work;

  assign sel  = IN_RANGE && (wr_edge == ffba_pkg::EDGE_W'(IDX));
  assign work = adv && in_ctl.valid;

  // latency column for this edge, registered read
  always_ff @(posedge clk) begin
    if (lat_we && sel) begin
      lat_mem[wr_addr] <= wr_lat;
    end
    lat_q <= lat_mem[rd_addr];
  end

  // grant and step arithmetic
  always_comb begin
    usable    = client_ok && (lat_q < limit) && (remaining != '0) && (in_left != '0);
    grant     = (remaining < in_left) ? remaining : in_left;
    sum       = {1'b0, used} + {1'b0, grant};
    used_sat  = sum[BW_BITS] ? {BW_BITS{1'b1}} : sum[BW_BITS-1:0];
    nz_inc    = (used != '0) && (nz_steps != {ffba_pkg::STEPS_W{1'b1}});
    nz_new    = nz_steps + ffba_pkg::STEPS_W'(nz_inc);
    grant_ext = {{ffba_pkg::VALUE_W{1'b0}}, grant};
    used_ext  = {{ffba_pkg::VALUE_W{1'b0}}, used};
  end

  // result offered to the top level
  always_comb begin
    res         = '0;
    res.edge_id = ffba_pkg::EDGE_W'(IDX);
    if (in_ctl.step) begin
      res.valid  = work;
      res.kind   = ffba_pkg::KIND_TOTAL;
      res.last   = IS_LAST;
      res.amount = used_ext[ffba_pkg::VALUE_W-1:0];
      res.steps  = nz_new;
    end else begin
      res.valid  = work && usable;
      res.kind   = ffba_pkg::KIND_GRANT;
      res.amount = grant_ext[ffba_pkg::VALUE_W-1:0];
    end
    if (!res.valid) begin
      res = '0;
    end
  end

  // edge state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= '0;
      remaining <= '0;
      used      <= '0;
      nz_steps  <= '0;
    end else if (cap_we && sel) begin
      capacity  <= wr_value;
      remaining <= wr_value;
    end else if (work && in_ctl.step) begin
      nz_steps  <= nz_new;
      remaining <= capacity;
      used      <= '0;
    end else if (work && usable) begin
      remaining <= remaining - grant;
      used      <= used_sat;
    end
  end

  // token stage to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left <= (!in_ctl.step && usable) ? in_left - grant : in_left;
    end
  end

endmodule

/* sv/first_fit_bandwidth_allocator.sv */
// First-fit bandwidth allocator: top level with the row of edge cells.
//
// Input beats (s_*) carry one of four operations in s_tuser: capacity load,
// latency load, client demand or end of step. Loads give no output beat.
// A demand sends a token down the row of edge cells, one cell per cycle
// while the m_* side does not stall the row; each cell with low enough latency and spare
// capacity grants min(demand left, capacity left) and emits a grant beat.
// The last grant beat carries the unserved remainder and tlast; a demand
// with no grant gives one zero grant beat. End of step sends the token
// through all cells, each emitting its step total, tlast on the final edge.
// A demand or end-of-step item occupies the block from acceptance through
// the token entry stage and every cell to the exit stage; s_tready is low meanwhile.
// The result register on m_* parts the sides: a new item may be taken
// while the final beat of the previous one waits. When m_tready is low and
// a beat is held, the token row freezes until the beat is taken.
// The APB port holds latency_limit at address 0 (reset value 400).
// Reset clears all capacity, usage and step counts; latency entries are
// undefined until loaded.
module first_fit_bandwidth_allocator #(
  parameter int NUM_EDGES   = 32,
  parameter int NUM_CLIENTS = 128,
  parameter int BW_BITS     = 20
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // edge_index[4:0], client_index[11:5], value[31:12]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_edge[4:0], out_client[11:5], amount[31:12],
                                 // unserved[51:32], active_steps[67:52], zero[71:68]
  output logic        m_tuser,   // kind
  output logic        m_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CLI_AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CW     = ffba_pkg::CLIENT_W;
  localparam int VW     = ffba_pkg::VALUE_W;

  // ---------------------------------------------------------------------
  // Input beat fields
  logic                  s_fire;
  logic [1:0]            in_func;
  logic [4:0]            in_edge;
  logic [CW-1:0]         in_client;
  logic [VW-1:0]         in_value;
  logic [CLI_AW+CW-1:0]  in_client_ext;
  logic [BW_BITS+VW-1:0] in_value_ext;
  logic                  in_client_ok;

  assign s_fire        = s_tvalid && s_tready;
  assign in_func       = s_tuser;
  assign in_edge       = s_tdata[4:0];
  assign in_client     = s_tdata[11:5];
  assign in_value      = s_tdata[31:12];
  assign in_client_ext = {{CLI_AW{1'b0}}, in_client};
  assign in_value_ext  = {{BW_BITS{1'b0}}, in_value};
  assign in_client_ok  = ({2'b00, in_client} < 9'(NUM_CLIENTS));

  // ---------------------------------------------------------------------
  // Configuration register
  logic [15:0] latency_limit;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      latency_limit <= ffba_pkg::LIMIT_RESET;
    end else if (cfg_we && (paddr[2] == ffba_pkg::REG_LATENCY_LIMIT)) begin
      latency_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ffba_pkg::REG_LATENCY_LIMIT) begin
      prdata = {16'd0, latency_limit};
    end
  end

  // ---------------------------------------------------------------------
  // Item control: busy while a token is in the row
  logic                    busy;
  logic                    adv;
  logic                    launch;
  logic [CW-1:0]           cur_client;
  logic                    cur_client_ok;
  logic [CLI_AW+CW-1:0]    cur_client_ext;
  logic [CLI_AW-1:0]       rd_addr;
  ffba_pkg::tok_ctl_t      tok0_ctl;
  logic [BW_BITS-1:0]      tok0_left;
  ffba_pkg::tok_ctl_t      chain_ctl  [NUM_EDGES+1];
  logic [BW_BITS-1:0]      chain_left [NUM_EDGES+1];
  ffba_pkg::tok_ctl_t      tail_ctl;
  logic [BW_BITS-1:0]      tail_left;
  logic                    tail_exit;
  logic                    out_valid;

  assign s_tready  = !busy;
  assign adv       = !out_valid || m_tready;
  assign launch    = s_fire && (in_func == ffba_pkg::FUNC_DEMAND ||
                                in_func == ffba_pkg::FUNC_STEP);
  assign tail_ctl  = chain_ctl[NUM_EDGES];
  assign tail_left = chain_left[NUM_EDGES];
  assign tail_exit = adv && tail_ctl.valid;

  assign cur_client_ext = {{CLI_AW{1'b0}}, cur_client};
  assign rd_addr = s_fire ? in_client_ext[CLI_AW-1:0] : cur_client_ext[CLI_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (launch) begin
      busy <= 1'b1;
    end else if (tail_exit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      cur_client    <= in_client;
      cur_client_ok <= in_client_ok;
      tok0_left     <= in_value_ext[BW_BITS-1:0];
    end
  end

  // token entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0_ctl <= '0;
    end else if (launch) begin
      tok0_ctl.valid <= 1'b1;
      tok0_ctl.step  <= (in_func == ffba_pkg::FUNC_STEP);
    end else if (adv) begin
      tok0_ctl.valid <= 1'b0;
    end
  end

  assign chain_ctl[0]  = tok0_ctl;
  assign chain_left[0] = tok0_left;

  // ---------------------------------------------------------------------
  // Row of edge cells
  ffba_pkg::cell_res_t   res_arr [NUM_EDGES];
  logic [NUM_EDGES-1:0]  res_vld;
  ffba_pkg::cell_res_t   res_all;
  logic                  cap_we;
  logic                  lat_we;

  assign cap_we = s_fire && (in_func == ffba_pkg::FUNC_CAP);
  assign lat_we = s_fire && (in_func == ffba_pkg::FUNC_LAT) && in_client_ok;

  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_cell
    ffba_cell #(
      .IDX         (i),
      .NUM_EDGES   (NUM_EDGES),
      .NUM_CLIENTS (NUM_CLIENTS),
      .BW_BITS     (BW_BITS),
      .CLI_AW      (CLI_AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_ctl    (chain_ctl[i]),
      .in_left   (chain_left[i]),
      .out_ctl   (chain_ctl[i+1]),
      .out_left  (chain_left[i+1]),
      .client_ok (cur_client_ok),
      .limit     (latency_limit),
      .rd_addr   (rd_addr),
      .wr_edge   (in_edge),
      .cap_we    (cap_we),
      .lat_we    (lat_we),
      .wr_addr   (in_client_ext[CLI_AW-1:0]),
      .wr_value  (in_value_ext[BW_BITS-1:0]),
      .wr_lat    (in_value[15:0]),
      .res       (res_arr[i])
    );
    assign res_vld[i] = res_arr[i].valid;
  end

  // only the cell holding the token offers a result; idle cells give zero
  always_comb begin
    res_all = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      res_all = res_all | res_arr[i];
    end
  end

  // ---------------------------------------------------------------------
  // Held grant: a grant is known to be the last one only later
  logic                   pend_valid;
  logic [4:0]             pend_edge;
  logic [VW-1:0]          pend_amount;
  logic [BW_BITS+VW-1:0]  tail_left_ext;

  assign tail_left_ext = {{VW{1'b0}}, tail_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (adv && res_all.valid && res_all.kind == ffba_pkg::KIND_GRANT) begin
      pend_valid <= 1'b1;
    end else if (tail_exit) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_all.valid && res_all.kind == ffba_pkg::KIND_GRANT) begin
      pend_edge   <= res_all.edge_id;
      pend_amount <= res_all.amount;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  logic                       out_load;
  logic                       out_kind;
  logic [4:0]                 out_edge;
  logic [CW-1:0]              out_client;
  logic [VW-1:0]              out_amount;
  logic [VW-1:0]              out_unserved;
  logic [ffba_pkg::STEPS_W-1:0] out_steps;
  logic                       out_last;
  logic                       ld_total;
  logic                       ld_grant;
  logic                       ld_final;

  assign ld_total = adv && res_all.valid && (res_all.kind == ffba_pkg::KIND_TOTAL);
  assign ld_grant = adv && res_all.valid && (res_all.kind == ffba_pkg::KIND_GRANT)
                    && pend_valid;
  assign ld_final = tail_exit && !tail_ctl.step;
  assign out_load = ld_total || ld_grant || ld_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_total) begin
      // edge step total
      out_kind     <= ffba_pkg::KIND_TOTAL;
      out_edge     <= res_all.edge_id;
      out_client   <= '0;
      out_amount   <= res_all.amount;
      out_unserved <= '0;
      out_steps    <= res_all.steps;
      out_last     <= res_all.last;
    end else if (ld_grant) begin
      // an earlier grant, now known not to be the last
      out_kind     <= ffba_pkg::KIND_GRANT;
      out_edge     <= pend_edge;
      out_client   <= cur_client;
      out_amount   <= pend_amount;
      out_unserved <= '0;
      out_steps    <= '0;
      out_last     <= 1'b0;
    end else if (ld_final) begin
      // closing grant, or the zero grant when nothing was granted
      out_kind     <= ffba_pkg::KIND_GRANT;
      out_edge     <= pend_valid ? pend_edge : 5'd0;
      out_client   <= cur_client;
      out_amount   <= pend_valid ? pend_amount : '0;
      out_unserved <= tail_left_ext[VW-1:0];
      out_steps    <= '0;
      out_last     <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'd0, out_steps, out_unserved, out_amount, out_client, out_edge};

`ifndef SYNTHESIS
  // a single token means at most one cell offers a result
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0(res_vld))
    else $error("more than one cell offered a result");

  // no token leaves the row while the block is idle
  a_tail_busy: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !tail_ctl.valid)
    else $error("token in the row while idle");

  // a held grant exists only during a demand walk
  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("held grant outside a demand");

  // the output register is never loaded over a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !out_load)
    else $error("result register overwritten");
`endif

endmodule

/* bench/first_fit_bandwidth_allocator_tb.sv */
// Self-checking testbench for the first-fit bandwidth allocator stream block.
module first_fit_bandwidth_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_EDGES   = 32;
  localparam int NUM_CLIENTS = 128;
  localparam int BW_BITS     = 20;
  localparam int SETTLE      = NUM_EDGES + 8;   // demand/step occupancy plus margin
  localparam logic [2:0] LIMIT_ADDR = {ffba_pkg::REG_LATENCY_LIMIT, 2'b00};

  typedef struct {
    logic [1:0]                    func;
    logic [ffba_pkg::EDGE_W-1:0]   edge_id;
    logic [ffba_pkg::CLIENT_W-1:0] client;
    logic [ffba_pkg::VALUE_W-1:0]  value;
  } item_t;

  typedef struct {
    logic                          kind;
    logic [ffba_pkg::EDGE_W-1:0]   edge_id;
    logic [ffba_pkg::CLIENT_W-1:0] client;
    logic [ffba_pkg::VALUE_W-1:0]  amount;
    logic [ffba_pkg::VALUE_W-1:0]  unserved;
    logic [ffba_pkg::STEPS_W-1:0]  steps;
    logic                          last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // edge_index[4:0], client_index[11:5], value[31:12]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // out_edge[4:0], out_client[11:5], amount[31:12],
                               // unserved[51:32], active_steps[67:52], zero[71:68]
  logic        m_tuser;        // kind
  logic        m_tlast;        // last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_bandwidth_allocator #(
    .NUM_EDGES(NUM_EDGES), .NUM_CLIENTS(NUM_CLIENTS), .BW_BITS(BW_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Allocator state as the block should hold it
  bit [ffba_pkg::VALUE_W-1:0] cap_tab  [NUM_EDGES];
  bit [ffba_pkg::VALUE_W-1:0] rem_tab  [NUM_EDGES];
  bit [ffba_pkg::VALUE_W-1:0] used_tab [NUM_EDGES];
  bit [ffba_pkg::STEPS_W-1:0] steps_tab[NUM_EDGES];
  bit [ffba_pkg::LAT_W-1:0]   lat_tab  [NUM_EDGES][NUM_CLIENTS];
  logic [ffba_pkg::LAT_W-1:0] limit_q = ffba_pkg::LIMIT_RESET;

  // Clients whose latency row is fully loaded before any demand goes out
  logic [ffba_pkg::CLIENT_W-1:0] served_clients[4] = '{7'd0, 7'd127, 7'd42, 7'd85};

  item_t stim_q[$];
  beat_t beats_due[$];
  item_t cur;
  int    mismatch_n = 0;
  int    gap_left = 0;
  int    burst_left = 0;
  int    stall_pct = 0;
  int    stretch_left = 0;

  // Apply one accepted item to the state and queue the beats it must produce
  task automatic predict_allocation(input item_t it);
    logic [ffba_pkg::VALUE_W-1:0] left;
    logic [ffba_pkg::VALUE_W-1:0] g;
    logic [ffba_pkg::VALUE_W:0]   sum;
    int                           n;
    beat_t                        b;
    n = 0;
    case (it.func)
      ffba_pkg::FUNC_CAP: begin
        cap_tab[it.edge_id] = it.value;
        rem_tab[it.edge_id] = it.value;
      end
      ffba_pkg::FUNC_LAT: lat_tab[it.edge_id][it.client] = it.value[ffba_pkg::LAT_W-1:0];
      ffba_pkg::FUNC_DEMAND: begin
        left = it.value;
        for (int e = 0; e < NUM_EDGES; e++) begin
          if (left != 0 && lat_tab[e][it.client] < limit_q && rem_tab[e] != 0) begin
            g = (rem_tab[e] < left) ? rem_tab[e] : left;
            left = left - g;
            rem_tab[e] = rem_tab[e] - g;
            sum = {1'b0, used_tab[e]} + g;
            used_tab[e] = sum[ffba_pkg::VALUE_W] ? '1 : sum[ffba_pkg::VALUE_W-1:0];
            b = '{ffba_pkg::KIND_GRANT, e[ffba_pkg::EDGE_W-1:0], it.client, g,
                  '0, '0, 1'b0};
            beats_due = {beats_due, b};
            n++;
          end
        end
        if (n == 0) begin
          // nothing granted: a single zero grant carries the whole demand
          b = '{ffba_pkg::KIND_GRANT, '0, it.client, '0, left, '0, 1'b1};
          beats_due = {beats_due, b};
        end else begin
          beats_due[beats_due.size()-1].unserved = left;
          beats_due[beats_due.size()-1].last = 1'b1;
        end
      end
      default: begin
        // end of step: one total per edge, then restore capacity
        for (int e = 0; e < NUM_EDGES; e++) begin
          if (used_tab[e] != 0 && steps_tab[e] != '1) steps_tab[e]++;
          b = '{ffba_pkg::KIND_TOTAL, e[ffba_pkg::EDGE_W-1:0], '0, used_tab[e], '0,
                steps_tab[e], e == NUM_EDGES - 1};
          beats_due = {beats_due, b};
          rem_tab[e] = cap_tab[e];
          used_tab[e] = '0;
        end
      end
    endcase
  endtask

  // Input driver: bursts of beats with random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_allocation(cur);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur.value, cur.client, cur.edge_id};
          s_tuser <= cur.func;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall density changes from stretch to stretch
  always @(posedge clk) begin
    if (stretch_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        3: stall_pct = 70;
        default: stall_pct = 90;
      endcase
      stretch_left = $urandom_range(50, 400);
    end else begin
      stretch_left--;
    end
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[4:0], m_tdata[11:5], m_tdata[31:12], m_tdata[51:32],
              m_tdata[67:52], m_tlast};
      if (beats_due.size() == 0) begin
        if (mismatch_n < 10)
          $display("%t unexpected beat: kind=%0d edge=%0d client=%0d amount=%0d last=%0d",
                   $realtime, got.kind, got.edge_id, got.client, got.amount, got.last);
        mismatch_n++;
      end else begin
        want = beats_due.pop_front();
        if (got.kind != want.kind || got.edge_id != want.edge_id ||
            got.client != want.client || got.amount != want.amount ||
            got.unserved != want.unserved || got.steps != want.steps ||
            got.last != want.last) begin
          if (mismatch_n < 10) begin
            $display("%t beat mismatch", $realtime);
            $display({"  exp kind=%0d edge=%0d client=%0d amount=%0d",
                      " unserved=%0d steps=%0d last=%0d"},
                     want.kind, want.edge_id, want.client, want.amount, want.unserved,
                     want.steps, want.last);
            $display({"  got kind=%0d edge=%0d client=%0d amount=%0d",
                      " unserved=%0d steps=%0d last=%0d"},
                     got.kind, got.edge_id, got.client, got.amount, got.unserved,
                     got.steps, got.last);
          end
          mismatch_n++;
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] f, input int e, input int c,
                          input logic [ffba_pkg::VALUE_W-1:0] v);
    item_t it;
    it = '{f, e[ffba_pkg::EDGE_W-1:0], c[ffba_pkg::CLIENT_W-1:0], v};
    stim_q = {stim_q, it};
  endtask

  // Latency around the current limit; the upper value bits are ignored junk
  function automatic logic [ffba_pkg::VALUE_W-1:0] pick_latency();
    logic [ffba_pkg::LAT_W-1:0] lat;
    case ($urandom_range(0, 5))
      0: lat = '0;
      1: lat = '1;
      2: lat = limit_q - 16'd1;
      3: lat = limit_q;
      4: lat = (limit_q == 0) ? 16'($urandom) : 16'($urandom_range(0, limit_q - 1));
      default: lat = 16'($urandom);
    endcase
    return {4'($urandom), lat};
  endfunction

  function automatic logic [ffba_pkg::VALUE_W-1:0] pick_bw();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 20'($urandom_range(1, 16));
      3: return 20'($urandom);
      default: return 20'($urandom_range(1, 6000));
    endcase
  endfunction

  // Mostly demands on loaded clients between loads and step boundaries
  task automatic add_random(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        add_item(ffba_pkg::FUNC_CAP, $urandom_range(0, 31), $urandom_range(0, 127),
                 pick_bw());
      else if (r < 24)
        add_item(ffba_pkg::FUNC_LAT, $urandom_range(0, 31),
                 served_clients[$urandom_range(0, 3)], pick_latency());
      else if (r < 28)
        add_item(ffba_pkg::FUNC_LAT, $urandom_range(0, 31), $urandom_range(0, 127),
                 pick_latency());
      else if (r < 88)
        add_item(ffba_pkg::FUNC_DEMAND, $urandom_range(0, 31),
                 served_clients[$urandom_range(0, 3)], pick_bw());
      else
        add_item(ffba_pkg::FUNC_STEP, $urandom_range(0, 31), $urandom_range(0, 127),
                 20'($urandom));
    end
  endtask

  // Block until every queued item is taken and every beat has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (stim_q.size() != 0 || s_tvalid || beats_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ffba_pkg::LAT_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_q = v;
  endtask

  // Stimulus sequence and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // preload capacities and full latency rows for the served clients
    for (int e = 0; e < NUM_EDGES; e++)
      add_item(ffba_pkg::FUNC_CAP, e, $urandom_range(0, 127),
               (e == 0) ? 20'hFFFFF : (e == 1) ? 20'd1 : (e == 5) ? 20'd0 : pick_bw());
    foreach (served_clients[i])
      for (int e = 0; e < NUM_EDGES; e++)
        add_item(ffba_pkg::FUNC_LAT, e, served_clients[i], pick_latency());
    // client 0: edge 0 at zero, edge 1 just under the limit, edge 2 at it
    add_item(ffba_pkg::FUNC_LAT, 0, 0, 20'h00000);
    add_item(ffba_pkg::FUNC_LAT, 1, 0, 20'hF018F);
    add_item(ffba_pkg::FUNC_LAT, 2, 0, 20'h00190);
    add_item(ffba_pkg::FUNC_LAT, 31, 127, 20'hFFFFF);

    // directed: zero demand, tiny and full demands, step totals
    add_item(ffba_pkg::FUNC_DEMAND, 0, 0, 20'd0);
    add_item(ffba_pkg::FUNC_DEMAND, 31, 0, 20'd1);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 127, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 42, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_STEP, 31, 127, 20'hFFFFF);
    // usage saturates after repeated capacity reloads within one step
    add_item(ffba_pkg::FUNC_CAP, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_CAP, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_CAP, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 0, 20'hFFFFF);
    add_item(ffba_pkg::FUNC_STEP, 0, 0, 20'd0);
    // exhausted and zero-capacity edges are skipped
    add_item(ffba_pkg::FUNC_CAP, 5, 0, 20'd0);
    add_item(ffba_pkg::FUNC_DEMAND, 0, 85, 20'd1000);
    add_item(ffba_pkg::FUNC_LAT, 31, 127, 20'h00000);
    add_item(ffba_pkg::FUNC_DEMAND, 31, 127, 20'd77);
    add_item(ffba_pkg::FUNC_STEP, 0, 0, 20'd0);
    add_random(16);
    wait_idle();

    // nothing is usable at a zero limit
    write_limit(16'd0);
    add_random(8);
    wait_idle();

    // every latency but the top one is usable
    write_limit(16'hFFFF);
    add_random(14);
    wait_idle();

    write_limit(16'($urandom_range(1, 65534)));
    add_random(12);
    wait_idle();

    if (mismatch_n == 0 && beats_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
